[design/itp_pkg.sv]
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types and constants for the integer text parser.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int MAX_CHARS = 1024;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int ACC_W     = 64;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    typedef enum logic [0:0] {
        CFG_FORCE_HEX   = 1'b0,
        CFG_NO_AUTO_HEX = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_char;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [ACC_W-1:0] parsed_value;
        logic             status;
        logic [CNT_W-1:0] consumed_count;
    } out_item_t;

    // classified byte, front to back
    typedef struct packed {
        logic       has_char;
        logic       is_last;
        logic       is_minus;
        logic       is_zero;
        logic       is_hash;
        logic       is_x;
        logic       is_dec;
        logic       is_hex;
        logic [3:0] dval;
    } cmd_t;

endpackage

[design/itp_front.sv]
// ----------------------------------------------------------------------------
// itp_front
// Accepts input transactions, classifies the byte and queues the result
// for the parse engine in a two-entry command queue.
// ----------------------------------------------------------------------------
module itp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  itp_pkg::in_item_t in_item,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output itp_pkg::cmd_t    cmd
);

    itp_pkg::cmd_t cls;
    itp_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          wr_en;
    logic          rd_en;
    logic          is_upper;
    logic          is_lower;

    always_comb
    begin
        is_upper     = (in_item.char_byte >= itp_pkg::CH_UA) &&
                       (in_item.char_byte <= itp_pkg::CH_UF);
        is_lower     = (in_item.char_byte >= itp_pkg::CH_LA) &&
                       (in_item.char_byte <= itp_pkg::CH_LF);
        cls.has_char = in_item.has_char;
        cls.is_last  = in_item.is_last;
        cls.is_minus = in_item.char_byte == itp_pkg::CH_MINUS;
        cls.is_zero  = in_item.char_byte == itp_pkg::CH_ZERO;
        cls.is_hash  = in_item.char_byte == itp_pkg::CH_HASH;
        cls.is_x     = (in_item.char_byte == itp_pkg::CH_LX) ||
                       (in_item.char_byte == itp_pkg::CH_UX);
        cls.is_dec   = (in_item.char_byte >= itp_pkg::CH_ZERO) &&
                       (in_item.char_byte <= itp_pkg::CH_NINE);
        cls.is_hex   = cls.is_dec || is_upper || is_lower;
        // letters: low nibble 1..6 maps to 10..15
        cls.dval     = cls.is_dec ? in_item.char_byte[3:0]
                                  : in_item.char_byte[3:0] + 4'd9;
    end

    assign full      = count_reg == 2'd2;
    assign cmd_valid = count_reg != 2'd0;
    assign cmd       = mem_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_valid && cmd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

[design/itp_back.sv]
// ----------------------------------------------------------------------------
// itp_back
// Parse engine: sign and prefix tracking, digit multiply-add with overflow
// check, consumed count, and a result register feeding the output queue.
// ----------------------------------------------------------------------------
module itp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  itp_pkg::cfg_idx_t  cfg_index,
    input  logic               cfg_data,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  itp_pkg::cmd_t      cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output itp_pkg::out_item_t res
);

    typedef enum logic [6:0] {
        PH_START  = 7'b0000001,
        PH_SIGN   = 7'b0000010,
        PH_ZERO   = 7'b0000100,
        PH_ZERO_X = 7'b0001000,
        PH_HASH   = 7'b0010000,
        PH_DIGITS = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    localparam int PROD_W = itp_pkg::ACC_W + 4;

    logic                      force_hex_reg;
    logic                      no_auto_hex_reg;
    phase_t                    phase_reg;
    logic [itp_pkg::ACC_W-1:0] acc_reg;
    logic                      hex_reg;
    logic                      neg_reg;
    logic                      ovf_reg;
    logic [itp_pkg::CNT_W-1:0] ds_reg;

    logic                      res_valid_reg;
    logic [itp_pkg::ACC_W-1:0] res_acc_reg;
    logic                      res_neg_reg;
    logic                      res_ovf_reg;
    logic [itp_pkg::CNT_W-1:0] res_ds_reg;

    logic                      take;
    logic                      res_take;
    phase_t                    phase_a;
    phase_t                    phase_next;
    logic                      hex_next;
    logic                      neg_next;
    logic                      ovf_next;
    logic [itp_pkg::ACC_W-1:0] acc_next;
    logic [itp_pkg::CNT_W-1:0] ds_next;
    logic [1:0]                pre_inc;
    logic                      feed_en;
    logic                      feed_hex;
    logic                      feed_inc;
    logic                      end_inc;
    logic [1:0]                inc_total;
    logic                      digit_ok;
    logic [PROD_W-1:0]         prod;
    logic [PROD_W-1:0]         sum;
    logic [itp_pkg::CNT_W:0]   ds_sum;

    assign cfg_ready = 1'b1;
    assign res_take  = res_valid_reg && res_ready;
    assign cmd_ready = !res_valid_reg || res_take;
    assign take      = cmd_valid && cmd_ready;

    // sign and prefix decisions
    always_comb
    begin
        phase_a  = phase_reg;
        hex_next = hex_reg;
        neg_next = neg_reg;
        pre_inc  = 2'd0;
        feed_en  = 1'b0;
        feed_hex = hex_reg;
        if (cmd.has_char)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    hex_next = force_hex_reg;
                    feed_hex = force_hex_reg;
                    if (cmd.is_minus)
                    begin
                        neg_next = 1'b1;
                        pre_inc  = 2'd1;
                        phase_a  = PH_SIGN;
                    end
                    else if (!no_auto_hex_reg && cmd.is_zero)
                    begin
                        phase_a = PH_ZERO;
                    end
                    else if (!no_auto_hex_reg && cmd.is_hash)
                    begin
                        phase_a = PH_HASH;
                    end
                    else
                    begin
                        feed_en = 1'b1;
                    end
                end
                PH_SIGN:
                begin
                    if (!no_auto_hex_reg && cmd.is_zero)
                    begin
                        phase_a = PH_ZERO;
                    end
                    else if (!no_auto_hex_reg && cmd.is_hash)
                    begin
                        phase_a = PH_HASH;
                    end
                    else
                    begin
                        feed_en = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    if (cmd.is_x)
                    begin
                        phase_a = PH_ZERO_X;
                    end
                    else
                    begin
                        // pending '0' becomes a digit; accumulator is still zero
                        pre_inc = 2'd1;
                        feed_en = 1'b1;
                    end
                end
                PH_ZERO_X:
                begin
                    hex_next = 1'b1;
                    feed_hex = 1'b1;
                    pre_inc  = 2'd2;
                    feed_en  = 1'b1;
                end
                PH_HASH:
                begin
                    hex_next = 1'b1;
                    feed_hex = 1'b1;
                    pre_inc  = 2'd1;
                    feed_en  = 1'b1;
                end
                PH_DIGITS:
                begin
                    feed_en = 1'b1;
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    assign digit_ok = cmd.is_dec || (feed_hex && cmd.is_hex);
    assign prod     = feed_hex ? {acc_reg, 4'b0000}
                               : ({1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0});
    assign sum      = prod + {{(PROD_W-4){1'b0}}, cmd.dval};

    // digit accumulation
    always_comb
    begin
        phase_next = phase_a;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        feed_inc   = 1'b0;
        if (feed_en)
        begin
            if (!digit_ok)
            begin
                phase_next = PH_DONE;
            end
            else if (|sum[PROD_W-1:itp_pkg::ACC_W])
            begin
                ovf_next   = 1'b1;
                acc_next   = '1;
                phase_next = PH_DONE;
            end
            else
            begin
                acc_next   = sum[itp_pkg::ACC_W-1:0];
                feed_inc   = 1'b1;
                phase_next = PH_DIGITS;
            end
        end
    end

    // a prefix candidate left at the end counts its '0' as a digit
    assign end_inc   = cmd.is_last && ((phase_next == PH_ZERO) || (phase_next == PH_ZERO_X));
    assign inc_total = pre_inc + {1'b0, feed_inc} + {1'b0, end_inc};
    assign ds_sum    = {1'b0, ds_reg} + {{(itp_pkg::CNT_W-1){1'b0}}, inc_total};
    assign ds_next   = (ds_sum > (itp_pkg::CNT_W+1)'(itp_pkg::MAX_CHARS))
                       ? itp_pkg::CNT_W'(itp_pkg::MAX_CHARS) : ds_sum[itp_pkg::CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_hex_reg   <= 1'b0;
            no_auto_hex_reg <= 1'b0;
            phase_reg       <= PH_START;
            acc_reg         <= '0;
            hex_reg         <= 1'b0;
            neg_reg         <= 1'b0;
            ovf_reg         <= 1'b0;
            ds_reg          <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    itp_pkg::CFG_FORCE_HEX:   force_hex_reg   <= cfg_data;
                    itp_pkg::CFG_NO_AUTO_HEX: no_auto_hex_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (take)
            begin
                if (cmd.is_last)
                begin
                    phase_reg <= PH_START;
                    acc_reg   <= '0;
                    hex_reg   <= 1'b0;
                    neg_reg   <= 1'b0;
                    ovf_reg   <= 1'b0;
                    ds_reg    <= '0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    acc_reg   <= acc_next;
                    hex_reg   <= hex_next;
                    neg_reg   <= neg_next;
                    ovf_reg   <= ovf_next;
                    ds_reg    <= ds_next;
                end
            end
            if (take && cmd.is_last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_take)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && cmd.is_last)
        begin
            res_acc_reg <= acc_next;
            res_neg_reg <= neg_next;
            res_ovf_reg <= ovf_next;
            res_ds_reg  <= ds_next;
        end
    end

    assign res_valid          = res_valid_reg;
    assign res.parsed_value   = res_ovf_reg ? '1
                              : (res_neg_reg ? ('0 - res_acc_reg) : res_acc_reg);
    assign res.status         = res_ovf_reg ? itp_pkg::ST_RANGE : itp_pkg::ST_OK;
    assign res.consumed_count = res_ovf_reg ? '0 : res_ds_reg;

endmodule

[design/itp_out_queue.sv]
// ----------------------------------------------------------------------------
// itp_out_queue
// Two-entry result queue presenting the oldest result to the consumer.
// ----------------------------------------------------------------------------
module itp_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  itp_pkg::out_item_t wr_item,
    input  logic               pop,
    output logic               empty,
    output itp_pkg::out_item_t out_item
);

    itp_pkg::out_item_t mem_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               wr_en;
    logic               rd_en;

    assign wr_ready = count_reg != 2'd2;
    assign empty    = count_reg == 2'd0;
    assign out_item = mem_reg[rd_ptr_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

[design/integer_text_parser.sv]
// ----------------------------------------------------------------------------
// integer_text_parser
// Parses a signed decimal or hex integer from a byte stream, one byte per
// transaction, and returns one result per string on its last transaction.
// Sustains one byte per clock cycle while the result register can drain;
// the rate is set by the parse engine, which does the accumulator
// multiply-add and overflow check for one byte each cycle. Queues of two
// entries on each side and a result register let input and output stall
// independently.
// ----------------------------------------------------------------------------
module integer_text_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  itp_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output itp_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  itp_pkg::cfg_idx_t  cfg_index,
    input  logic               cfg_data
);

    logic               cmd_valid;
    logic               cmd_ready;
    itp_pkg::cmd_t      cmd;
    logic               res_valid;
    logic               res_ready;
    itp_pkg::out_item_t res;

    itp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    itp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    itp_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_ready (res_ready),
        .wr_item  (res),
        .pop      (pop),
        .empty    (empty),
        .out_item (out_item)
    );

    a_range_form: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.status == itp_pkg::ST_RANGE) |->
        (out_item.consumed_count == '0 && out_item.parsed_value == '1))
        else $error("out-of-range transaction with nonzero count or value");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_item.consumed_count <= itp_pkg::CNT_W'(itp_pkg::MAX_CHARS)))
        else $error("consumed count above bound");

    a_nothing_parsed: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.status == itp_pkg::ST_OK && out_item.consumed_count == '0) |->
        (out_item.parsed_value == '0))
        else $error("nonzero value with nothing consumed");

    a_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_ready) |=> cmd_valid)
        else $error("command queue lost a stalled entry");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer text parser. Strings are queued as byte
// transactions and pushed with random gaps. Each accepted byte goes through a
// local parse model, and every popped result is compared against the oldest
// predicted one. Runs a short directed set, then random strings under four
// register settings, with one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          HOLD_AT     = 12;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN_WAIT  = 12;
    localparam int          RAND_ITEMS  = 180;
    localparam logic [4:0]  NO_DIGIT    = 5'd16;
    localparam bit   [3:0]  FH_PLAN     = 4'b0101;
    localparam bit   [3:0]  NAH_PLAN    = 4'b0110;

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_SIGN,
        SCAN_ZERO,
        SCAN_ZERO_X,
        SCAN_HASH,
        SCAN_DIGITS,
        SCAN_DONE
    } scan_state_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                push      = 1'b0;
    logic                full;
    itp_pkg::in_item_t   in_item   = '0;
    logic                empty;
    logic                pop       = 1'b0;
    itp_pkg::out_item_t  out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    itp_pkg::cfg_idx_t   cfg_index = itp_pkg::CFG_FORCE_HEX;
    logic                cfg_data  = 1'b0;

    itp_pkg::in_item_t   byte_stream[$];
    itp_pkg::out_item_t  predicted_results[$];

    // parse model state
    logic [itp_pkg::ACC_W-1:0] acc_value    = '0;
    logic [itp_pkg::CNT_W-1:0] accepted_cnt = '0;
    scan_state_t               scan_state   = SCAN_START;
    logic                      hex_now      = 1'b0;
    logic                      minus_seen   = 1'b0;
    logic                      range_err    = 1'b0;
    logic                      reg_force_hex   = 1'b0;
    logic                      reg_no_auto_hex = 1'b0;

    int items_queued = 0;
    int bytes_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int input_stalls = 0;
    int tx_gap       = 0;
    int tx_calm      = 0;
    int rx_gap       = 0;
    int rx_calm      = 0;
    int hold_cnt     = 0;
    bit hold_done    = 1'b0;

    integer_text_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [itp_pkg::CNT_W-1:0] sat_add(logic [itp_pkg::CNT_W-1:0] v,
                                                          int unsigned by);
        int unsigned s;
        s = v + by;
        return (s > itp_pkg::MAX_CHARS) ? itp_pkg::CNT_W'(itp_pkg::MAX_CHARS)
                                        : itp_pkg::CNT_W'(s);
    endfunction

    function automatic logic [4:0] digit_value(logic [7:0] b, logic hexm);
        if (b >= itp_pkg::CH_ZERO && b <= itp_pkg::CH_NINE)
            return 5'(b - itp_pkg::CH_ZERO);
        if (hexm && b >= itp_pkg::CH_UA && b <= itp_pkg::CH_UF)
            return 5'(b - itp_pkg::CH_UA + 8'd10);
        if (hexm && b >= itp_pkg::CH_LA && b <= itp_pkg::CH_LF)
            return 5'(b - itp_pkg::CH_LA + 8'd10);
        return NO_DIGIT;
    endfunction

    task automatic take_digit(logic [7:0] b);
        logic [4:0]                d;
        logic [itp_pkg::ACC_W-1:0] radix;
        if (scan_state != SCAN_DIGITS)
            return;
        d = digit_value(b, hex_now);
        if (d == NO_DIGIT)
        begin
            scan_state = SCAN_DONE;
            return;
        end
        radix = hex_now ? 64'd16 : 64'd10;
        if (acc_value > ({itp_pkg::ACC_W{1'b1}} - itp_pkg::ACC_W'(d)) / radix)
        begin
            range_err  = 1'b1;
            acc_value  = '1;
            scan_state = SCAN_DONE;
            return;
        end
        acc_value    = radix * acc_value + itp_pkg::ACC_W'(d);
        accepted_cnt = sat_add(accepted_cnt, 1);
    endtask

    task automatic check_prefix(logic [7:0] b);
        if (!reg_no_auto_hex && b == itp_pkg::CH_ZERO)
            scan_state = SCAN_ZERO;
        else if (!reg_no_auto_hex && b == itp_pkg::CH_HASH)
            scan_state = SCAN_HASH;
        else
        begin
            scan_state = SCAN_DIGITS;
            take_digit(b);
        end
    endtask

    task automatic consume_byte(logic [7:0] b);
        case (scan_state)
            SCAN_START:
            begin
                hex_now = reg_force_hex;
                if (b == itp_pkg::CH_MINUS)
                begin
                    minus_seen   = 1'b1;
                    accepted_cnt = sat_add(accepted_cnt, 1);
                    scan_state   = SCAN_SIGN;
                end
                else
                    check_prefix(b);
            end
            SCAN_SIGN:
                check_prefix(b);
            SCAN_ZERO:
            begin
                if (b == itp_pkg::CH_LX || b == itp_pkg::CH_UX)
                    scan_state = SCAN_ZERO_X;
                else
                begin
                    scan_state = SCAN_DIGITS;
                    take_digit(itp_pkg::CH_ZERO);
                    take_digit(b);
                end
            end
            SCAN_ZERO_X:
            begin
                hex_now      = 1'b1;
                accepted_cnt = sat_add(accepted_cnt, 2);
                scan_state   = SCAN_DIGITS;
                take_digit(b);
            end
            SCAN_HASH:
            begin
                hex_now      = 1'b1;
                accepted_cnt = sat_add(accepted_cnt, 1);
                scan_state   = SCAN_DIGITS;
                take_digit(b);
            end
            SCAN_DIGITS:
                take_digit(b);
            default:
            begin
            end
        endcase
    endtask

    task automatic parse_predict(itp_pkg::in_item_t it);
        itp_pkg::out_item_t r;
        if (it.has_char)
            consume_byte(it.char_byte);
        if (!it.is_last)
            return;
        // a pending 0 or 0x at end of string: the zero counts as a digit
        if (scan_state == SCAN_ZERO || scan_state == SCAN_ZERO_X)
        begin
            scan_state = SCAN_DIGITS;
            take_digit(itp_pkg::CH_ZERO);
            scan_state = SCAN_DONE;
        end
        if (range_err)
        begin
            r.parsed_value   = '1;
            r.status         = itp_pkg::ST_RANGE;
            r.consumed_count = '0;
        end
        else
        begin
            r.parsed_value   = minus_seen ? (64'd0 - acc_value) : acc_value;
            r.status         = itp_pkg::ST_OK;
            r.consumed_count = accepted_cnt;
        end
        predicted_results.push_back(r);
        acc_value    = '0;
        accepted_cnt = '0;
        scan_state   = SCAN_START;
        hex_now      = 1'b0;
        minus_seen   = 1'b0;
        range_err    = 1'b0;
    endtask

    task automatic log_mismatch(string field, itp_pkg::out_item_t want,
                                itp_pkg::out_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch (%s) at result %0d: exp %h/%0d/%0d got %h/%0d/%0d",
                     field, results_seen, want.parsed_value, want.status,
                     want.consumed_count, got.parsed_value, got.status,
                     got.consumed_count);
    endtask

    task automatic check_result(itp_pkg::out_item_t got);
        itp_pkg::out_item_t want;
        results_seen++;
        if (predicted_results.size() == 0)
        begin
            log_mismatch("unexpected transaction", '0, got);
            return;
        end
        want = predicted_results.pop_front();
        if (got.parsed_value !== want.parsed_value)
            log_mismatch("parsed_value", want, got);
        else if (got.status !== want.status)
            log_mismatch("status", want, got);
        else if (got.consumed_count !== want.consumed_count)
            log_mismatch("consumed_count", want, got);
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push    <= 1'b0;
            in_item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                parse_predict(in_item);
                void'(byte_stream.pop_front());
                bytes_sent++;
                tx_gap = pick_gap(tx_calm);
            end
            if (push && full)
                input_stalls++;
            else if (tx_gap > 0)
            begin
                tx_gap--;
                push <= 1'b0;
            end
            else if (byte_stream.size() > 0)
            begin
                push    <= 1'b1;
                in_item <= byte_stream[0];
            end
            else
                push <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                check_result(out_item);
                rx_gap = pick_gap(rx_calm);
                if (results_seen == HOLD_AT && !hold_done)
                begin
                    hold_cnt  = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                pop <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic add_item(logic [7:0] b, bit has, bit last);
        itp_pkg::in_item_t it;
        it.char_byte = b;
        it.has_char  = has;
        it.is_last   = last;
        byte_stream.push_back(it);
        items_queued++;
    endtask

    task automatic add_text(string s, bit split_end);
        for (int i = 0; i < s.len(); i++)
            add_item(s[i], 1'b1, !split_end && i == s.len() - 1);
        if (split_end)
            add_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic add_random_string();
        logic [7:0] text[$];
        string      hex_chars;
        int         r;
        int         len;
        int         pfx;
        bit         hexd;
        bit         split_end;
        hex_chars = "0123456789abcdefABCDEF";
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                add_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
                         i == len - 1);
            return;
        end
        if (r < 13)
        begin
            case ($urandom_range(0, 5))
                0: add_text("18446744073709551615", 0);
                1: add_text("18446744073709551616", 0);
                2: add_text("#ffffffffffffffff", 1);
                3: add_text("0x10000000000000000", 0);
                4: add_text("-9223372036854775808", 0);
                default: add_text("-0", 1);
            endcase
            return;
        end
        if ($urandom_range(0, 2) == 0)
            text.push_back(itp_pkg::CH_MINUS);
        pfx = $urandom_range(0, 5);
        if (pfx == 0)
        begin
            text.push_back(itp_pkg::CH_ZERO);
            text.push_back(itp_pkg::CH_LX);
        end
        else if (pfx == 1)
        begin
            text.push_back(itp_pkg::CH_ZERO);
            text.push_back(itp_pkg::CH_UX);
        end
        else if (pfx == 2)
            text.push_back(itp_pkg::CH_HASH);
        hexd = pfx < 3 || reg_force_hex || $urandom_range(0, 7) == 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            len = $urandom_range(1, 6);
        else if (r < 94)
            len = $urandom_range(7, 16);
        else
            len = $urandom_range(17, 24);
        for (int i = 0; i < len; i++)
            if (hexd)
                text.push_back(hex_chars[$urandom_range(0, 21)]);
            else
                text.push_back(hex_chars[$urandom_range(0, 9)]);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                text.push_back(8'($urandom_range(0, 255)));
        split_end = $urandom_range(0, 4) == 0;
        for (int i = 0; i < text.size(); i++)
        begin
            if ($urandom_range(0, 19) == 0)
                add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            add_item(text[i], 1'b1, !split_end && i == text.size() - 1);
        end
        if (split_end)
            add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic write_reg(itp_pkg::cfg_idx_t idx, logic val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            itp_pkg::CFG_FORCE_HEX:   reg_force_hex   = val;
            itp_pkg::CFG_NO_AUTO_HEX: reg_no_auto_hex = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic wait_idle();
        while (byte_stream.size() != 0 || predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial
    begin
        int goal;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_text("-", 0);
        add_text("", 1);
        add_text("0x", 0);
        add_text("#", 0);
        add_text("0Xz", 0);
        add_text("-#aF", 0);
        add_text("-0X", 0);
        add_item(8'h39, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'hFF, 1'b1, 1'b1);
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            write_reg(itp_pkg::CFG_FORCE_HEX, FH_PLAN[p]);
            write_reg(itp_pkg::CFG_NO_AUTO_HEX, NAH_PLAN[p]);
            @(negedge clk);
            goal = items_queued + RAND_ITEMS;
            while (items_queued < goal)
                add_random_string();
            wait_idle();
        end

        $display("Covered %0d byte transactions and %0d parsed strings over four register",
                 bytes_sent, results_seen);
        $display("settings; input was held off for %0d cycles, %0d mismatches",
                 input_stalls, mismatches);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
